### hdl/grid_window_max_product_unit_assert.svh
// ----------------------------------------------------------------------------
// Grid window max product assertion macros
// Shorthand for the concurrent checks of the grid window max product unit.
// ----------------------------------------------------------------------------
`ifndef GRID_WINDOW_MAX_PRODUCT_UNIT_ASSERT_SVH
`define GRID_WINDOW_MAX_PRODUCT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define GWMP_ASSERT_IMPLIES(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define GWMP_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/gwmp_pkg.sv
// ----------------------------------------------------------------------------
// Grid window max product package
// Shared widths, reset values, register indexes and the item flag type.
// ----------------------------------------------------------------------------
package gwmp_pkg;

  localparam int DATA_W             = 8;
  localparam int RESULT_W           = 32;
  localparam int GRID_SIZE_W        = 6;
  localparam int WINDOW_LEN_W       = 3;
  localparam int CFG_INDEX_W        = 1;
  localparam int CFG_DATA_W         = 6;
  localparam int DEFAULT_MAX_GRID   = 32;
  localparam int DEFAULT_MAX_WINDOW = 4;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [GRID_SIZE_W-1:0]  GRID_SIZE_RESET  = 6'd20;
  localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RESET = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN = 1'd1;

  typedef struct packed {
    logic row_ok;
    logic col_ok;
    logic diag_ok;
    logic anti_ok;
    logic row_end;
    logic grid_end;
  } item_flags_t;

  localparam int FLAGS_W = $bits(item_flags_t);

  typedef struct packed {
    logic busy;
    logic emitting;
  } back_status_t;

endpackage

### hdl/gwmp_ram.sv
// ----------------------------------------------------------------------------
// Grid window max product RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gwmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/gwmp_queue.sv
// ----------------------------------------------------------------------------
// Grid window max product item queue
// Short register FIFO between the classifying front and the compute back.
// ----------------------------------------------------------------------------
module gwmp_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = gwmp_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= wdata;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/gwmp_front.sv
// ----------------------------------------------------------------------------
// Grid window max product front end
// Accepts cells, tracks the raster position and marks which windows fit.
// ----------------------------------------------------------------------------
module gwmp_front #(
  parameter int MAX_GRID   = gwmp_pkg::DEFAULT_MAX_GRID,
  parameter int MAX_WINDOW = gwmp_pkg::DEFAULT_MAX_WINDOW,
  localparam int COL_W  = $clog2(MAX_GRID),
  localparam int NW     = $clog2(MAX_GRID + 1),
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1),
  localparam int ITEM_W = gwmp_pkg::FLAGS_W + COL_W + gwmp_pkg::DATA_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic [NW-1:0]               n_eff,
  input  logic [LEN_W-1:0]            len_eff,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [gwmp_pkg::DATA_W-1:0] s_axis_tdata,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [ITEM_W-1:0]           q_data
);

  localparam int SUM_W = NW + LEN_W;

  logic [COL_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic [LEN_W-1:0]     len_m1;
  gwmp_pkg::item_flags_t flags;

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;
  assign len_m1        = len_eff - LEN_W'(1);

  always_comb begin
    flags.row_ok   = (col >= len_m1);
    flags.col_ok   = (row >= len_m1);
    flags.diag_ok  = flags.row_ok && flags.col_ok;
    flags.anti_ok  = flags.col_ok &&
                     (SUM_W'(col) + SUM_W'(len_m1) <= SUM_W'(n_eff) - SUM_W'(1));
    flags.row_end  = (NW'(col) == n_eff - NW'(1));
    flags.grid_end = flags.row_end && (NW'(row) == n_eff - NW'(1));
  end

  assign q_data = {flags, col, s_axis_tdata};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row <= '0;
      col <= '0;
    end else if (q_push) begin
      if (flags.grid_end) begin
        row <= '0;
        col <= '0;
      end else if (flags.row_end) begin
        row <= row + COL_W'(1);
        col <= '0;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

### hdl/gwmp_back.sv
// ----------------------------------------------------------------------------
// Grid window max product back end
// Reads the line store, multiplies each window and keeps the running maximum.
// ----------------------------------------------------------------------------
module gwmp_back #(
  parameter int MAX_GRID   = gwmp_pkg::DEFAULT_MAX_GRID,
  parameter int MAX_WINDOW = gwmp_pkg::DEFAULT_MAX_WINDOW,
  localparam int COL_W  = $clog2(MAX_GRID),
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1),
  localparam int ITEM_W = gwmp_pkg::FLAGS_W + COL_W + gwmp_pkg::DATA_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [LEN_W-1:0]              len_eff,
  input  logic                          q_valid,
  input  logic [ITEM_W-1:0]             q_data,
  output logic                          q_pop,
  output gwmp_pkg::back_status_t        status,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [gwmp_pkg::RESULT_W-1:0] m_axis_tdata
);

  localparam int DATA_W    = gwmp_pkg::DATA_W;
  localparam int SLOT_W    = $clog2(MAX_WINDOW);
  localparam int KW        = SLOT_W;
  localparam int P_W       = DATA_W * MAX_WINDOW;
  localparam int RAM_DEPTH = MAX_WINDOW * (2 ** COL_W);
  localparam int ADDR_W    = SLOT_W + COL_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_READ, S_MUL, S_CMP, S_STORE, S_EMIT
  } state_t;

  typedef enum logic [1:0] {DIR_ROW, DIR_COL, DIR_DIAG, DIR_ANTI} dir_t;

  state_t                  state;
  dir_t                    dir;
  logic [KW-1:0]           k;
  logic [P_W-1:0]          prod;
  logic [DATA_W-1:0]       pixel;
  logic [COL_W-1:0]        col;
  gwmp_pkg::item_flags_t   flags;
  logic [SLOT_W-1:0]       slot;
  logic [gwmp_pkg::RESULT_W-1:0] best;

  logic [LEN_W-1:0]  len_m1;
  logic              dir_ok;
  logic [SLOT_W:0]   slot_wrap;
  logic [SLOT_W-1:0] slot_up;
  logic [SLOT_W-1:0] rd_slot;
  logic [COL_W-1:0]  rd_col;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic              we;
  logic [DATA_W-1:0] rdata;
  logic [P_W-1:0]    prod_mul;

  assign len_m1   = len_eff - LEN_W'(1);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign status.busy     = (state != S_IDLE);
  assign status.emitting = (state == S_EMIT);
  assign prod_mul = prod * P_W'(rdata);

  always_comb begin
    case (dir)
      DIR_ROW:  dir_ok = flags.row_ok;
      DIR_COL:  dir_ok = flags.col_ok;
      DIR_DIAG: dir_ok = flags.diag_ok;
      DIR_ANTI: dir_ok = flags.anti_ok;
      default:  dir_ok = 1'b0;
    endcase
  end

  always_comb begin
    slot_wrap = (slot >= k) ? (SLOT_W+1)'(slot) - (SLOT_W+1)'(k)
                            : (SLOT_W+1)'(slot) + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(k);
    slot_up   = SLOT_W'(slot_wrap);
    case (dir)
      DIR_ROW: begin
        rd_slot = slot;
        rd_col  = col - COL_W'(k);
      end
      DIR_COL: begin
        rd_slot = slot_up;
        rd_col  = col;
      end
      DIR_DIAG: begin
        rd_slot = slot_up;
        rd_col  = col - COL_W'(k);
      end
      default: begin
        rd_slot = slot_up;
        rd_col  = col + COL_W'(k);
      end
    endcase
  end

  assign raddr = {rd_slot, rd_col};
  assign waddr = {slot, col};
  assign we    = (state == S_STORE);

  gwmp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (pixel),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      best          <= '0;
      slot          <= '0;
    end else begin
      if ((state == S_EMIT) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (restart) begin
        best <= '0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            pixel <= q_data[DATA_W-1:0];
            col   <= q_data[DATA_W +: COL_W];
            flags <= gwmp_pkg::item_flags_t'(q_data[ITEM_W-1 -: gwmp_pkg::FLAGS_W]);
            dir   <= DIR_ROW;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (dir_ok) begin
            prod  <= P_W'(pixel);
            k     <= KW'(1);
            state <= (len_m1 == '0) ? S_CMP : S_READ;
          end else if (dir == DIR_ANTI) begin
            state <= S_STORE;
          end else begin
            dir <= dir_t'(dir + 2'd1);
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= prod_mul;
          if (LEN_W'(k) == len_m1) begin
            state <= S_CMP;
          end else begin
            k     <= k + KW'(1);
            state <= S_READ;
          end
        end
        S_CMP: begin
          if (prod > P_W'(best)) begin
            best <= gwmp_pkg::RESULT_W'(prod);
          end
          if (dir == DIR_ANTI) begin
            state <= S_STORE;
          end else begin
            dir   <= dir_t'(dir + 2'd1);
            state <= S_SETUP;
          end
        end
        S_STORE: begin
          if (flags.row_end) begin
            slot <= (slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
          end
          state <= flags.grid_end ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= best;
            best          <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/grid_window_max_product_unit.sv
// ----------------------------------------------------------------------------
// Grid window max product unit
// Streams a square grid in raster order and reports the largest product of
// window_len adjacent cells along rows, columns and both diagonals.
// ----------------------------------------------------------------------------
// Cells enter on the s_axis channel, one 8-bit cell per transfer, row by row.
// After the last cell of a grid one 32-bit result leaves on the m_axis
// channel, and the next grid starts with the following cell.
// The register port sets grid_size (index 0) and window_len (index 1); any
// write restarts the grid and must only happen while the unit is idle.
// A two-entry queue sits between the input side and the compute engine, so
// up to two cells are taken while the engine is busy.
// The engine handles one cell at a time and works through the windows (0 to
// 4) that end at that cell, one direction after another, with the effective
// window length. Its pace is set by the single read port of the line store
// and the one shared multiplier, which take one store read and one multiply
// per window cell after the first. For the last cell of a grid the engine
// then loads the output register in its emit step.
// Reset restores grid_size 20 and window_len 4 and empties the queue.
// While the receiver holds m_axis_tready low the result stays in the output
// register; the engine keeps working and stalls only on the next result.
// ----------------------------------------------------------------------------
`include "grid_window_max_product_unit_assert.svh"

module grid_window_max_product_unit #(
  parameter int MAX_GRID   = gwmp_pkg::DEFAULT_MAX_GRID,
  parameter int MAX_WINDOW = gwmp_pkg::DEFAULT_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gwmp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gwmp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gwmp_pkg::DATA_W-1:0]      s_axis_tdata,   // [7:0] cell_value
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gwmp_pkg::RESULT_W-1:0]    m_axis_tdata    // [31:0] max_product
);

  localparam int COL_W  = $clog2(MAX_GRID);
  localparam int NW     = $clog2(MAX_GRID + 1);
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int ITEM_W = gwmp_pkg::FLAGS_W + COL_W + gwmp_pkg::DATA_W;

  logic [gwmp_pkg::GRID_SIZE_W-1:0]  grid_size;
  logic [gwmp_pkg::WINDOW_LEN_W-1:0] window_len;
  logic [NW-1:0]                     n_eff;
  logic [LEN_W-1:0]                  len_eff;

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [ITEM_W-1:0] q_wdata;
  logic [ITEM_W-1:0] q_rdata;
  gwmp_pkg::back_status_t back_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= gwmp_pkg::GRID_SIZE_RESET;
      window_len <= gwmp_pkg::WINDOW_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gwmp_pkg::REG_GRID_SIZE:  grid_size  <= cfg_wdata[gwmp_pkg::GRID_SIZE_W-1:0];
        gwmp_pkg::REG_WINDOW_LEN: window_len <= cfg_wdata[gwmp_pkg::WINDOW_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (grid_size == '0) begin
      n_eff = NW'(1);
    end else if (32'(grid_size) > 32'(MAX_GRID)) begin
      n_eff = NW'(MAX_GRID);
    end else begin
      n_eff = NW'(grid_size);
    end
    if (window_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = LEN_W'(window_len);
    end
  end

  gwmp_front #(
    .MAX_GRID   (MAX_GRID),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_we),
    .n_eff         (n_eff),
    .len_eff       (len_eff),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  gwmp_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (gwmp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  gwmp_back #(
    .MAX_GRID   (MAX_GRID),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_we),
    .len_eff       (len_eff),
    .q_valid       (q_valid),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .status        (back_status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `GWMP_ASSERT_IMPLIES(a_pop_when_ready, clk, rst, q_pop, q_valid && !back_status.busy, "engine took a cell while busy or from an empty queue")
  `GWMP_ASSERT_IMPLIES(a_push_not_full, clk, rst, q_push, !q_full, "cell pushed into a full queue")
  `GWMP_ASSERT_NEXT(a_push_visible, clk, rst, q_push && !q_pop, q_valid, "pushed cell not visible to the engine")
  `GWMP_ASSERT_IMPLIES(a_result_source, clk, rst, $rose(m_axis_tvalid), $past(back_status.emitting), "result appeared outside of the emit step")

endmodule
